[rtl/core/variable_record_ring_fifo_macros.svh]
// ---------------------------------------------------------------------------
// variable_record_ring_fifo_macros
// assertion helpers used by the checker file
// ---------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_RING_FIFO_MACROS_SVH
`define VARIABLE_RECORD_RING_FIFO_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VRRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrrf assertion failed");

// next-cycle implication, disabled while in reset
`define VRRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrrf assertion failed");

`endif

[rtl/core/vrrf_pkg.sv]
// ---------------------------------------------------------------------------
// vrrf_pkg
// types and constants of the variable-length record ring fifo
// ---------------------------------------------------------------------------
`default_nettype none

package vrrf_pkg;

    // ring geometry
    localparam int RING_BYTES   = 1024;
    localparam int HEADER_BYTES = 2;
    localparam int MIN_SIZE     = 4;

    // derived widths
    localparam int IDX_W   = $clog2(RING_BYTES);
    localparam int SIZE_W  = $clog2(RING_BYTES + 1);
    localparam int SUM_W   = SIZE_W + 1;
    localparam int COUNT_W = $clog2(RING_BYTES / (HEADER_BYTES + 1) + 1);
    localparam int HDR_W   = 8 * HEADER_BYTES;
    localparam int HIDX_W  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

    // field widths
    localparam int REQ_W    = 3;
    localparam int LEN_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CNT_OUT_W  = 9;
    localparam int FREE_OUT_W = 11;
    localparam int CFG_W    = 11;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_START = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_DATA  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP        = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FLUSH      = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SEQ_ERR  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OFFSET   = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [LEN_W-1:0]  elem_len;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  read_offset;
        logic [LEN_W-1:0]  max_len;
    } vrrf_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [BYTE_W-1:0]     data_out;
        logic [LEN_W-1:0]      length_out;
        logic [CNT_OUT_W-1:0]  count_out;
        logic [FREE_OUT_W-1:0] free_out;
    } vrrf_rsp_t;

endpackage

`default_nettype wire

[rtl/core/variable_record_ring_fifo.sv]
// Results: every result is registered and shown on done with rsp. Push start writes the header
//   bytes one at a time; pop and read fetch them one at a time through the ring ram, and a
//   read whose offset lies within the read length then reads its data byte as well.
// Throughput: one request at a time; the next can be accepted in the cycle its result shows.
// Reset: ring empty, buffer size 1024, ram contents left as they are (no clearing pass).
// ---------------------------------------------------------------------------
// variable_record_ring_fifo
// byte ring of length-prefixed records with push, read, pop and flush
// ---------------------------------------------------------------------------
`default_nettype none

module variable_record_ring_fifo (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire vrrf_pkg::vrrf_req_t               req,
    output logic                                   done,
    output vrrf_pkg::vrrf_rsp_t                    rsp,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vrrf_pkg::CFG_W-1:0]        cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_HWR  = 7'b0000100,
        S_HRD  = 7'b0001000,
        S_HCAP = 7'b0010000,
        S_ACT  = 7'b0100000,
        S_DRD  = 7'b1000000
    } state_t;

    localparam int WIDE_W = vrrf_pkg::HDR_W + vrrf_pkg::LEN_W;
    localparam logic [WIDE_W:0] HDR_LIMIT = (WIDE_W + 1)'(1) << vrrf_pkg::HDR_W;
    localparam logic [vrrf_pkg::HIDX_W-1:0] HIDX_LAST =
        vrrf_pkg::HIDX_W'(vrrf_pkg::HEADER_BYTES - 1);

    // wrap a sum known to stay below twice the ring size
    function automatic logic [vrrf_pkg::IDX_W-1:0] wrap_idx(
        input logic [vrrf_pkg::SUM_W-1:0]  sum,
        input logic [vrrf_pkg::SIZE_W-1:0] size
    );
        logic [vrrf_pkg::SUM_W-1:0] s;
        s = vrrf_pkg::SUM_W'(size);
        if (sum >= s)
        begin
            return vrrf_pkg::IDX_W'(sum - s);
        end
        return vrrf_pkg::IDX_W'(sum);
    endfunction

    // clamp the written buffer size to the usable range
    function automatic logic [vrrf_pkg::SIZE_W-1:0] clamp_size(
        input logic [vrrf_pkg::CFG_W-1:0] v
    );
        if (32'(v) < 32'(vrrf_pkg::MIN_SIZE))
        begin
            return vrrf_pkg::SIZE_W'(vrrf_pkg::MIN_SIZE);
        end
        if (32'(v) > 32'(vrrf_pkg::RING_BYTES))
        begin
            return vrrf_pkg::SIZE_W'(vrrf_pkg::RING_BYTES);
        end
        return vrrf_pkg::SIZE_W'(v);
    endfunction

    state_t                          state_reg, state_next;
    vrrf_pkg::vrrf_req_t             req_reg, req_next;
    logic [vrrf_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [vrrf_pkg::IDX_W-1:0]      rear_reg, rear_next;
    logic [vrrf_pkg::IDX_W-1:0]      front_reg, front_next;
    logic [vrrf_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [vrrf_pkg::SIZE_W-1:0]     free_reg, free_next;
    logic [vrrf_pkg::LEN_W-1:0]      fill_reg, fill_next;
    logic [vrrf_pkg::HIDX_W-1:0]     hidx_reg, hidx_next;
    logic [vrrf_pkg::IDX_W-1:0]      addr_reg, addr_next;
    logic [vrrf_pkg::HDR_W-1:0]      hdr_reg, hdr_next;
    logic                            done_reg, done_next;
    vrrf_pkg::vrrf_rsp_t             rsp_reg, rsp_next;

    // ram port signals
    logic                            ram_we;
    logic [vrrf_pkg::IDX_W-1:0]      ram_waddr;
    logic [vrrf_pkg::BYTE_W-1:0]     ram_wdata;
    logic                            ram_re;
    logic [vrrf_pkg::IDX_W-1:0]      ram_raddr;
    logic [vrrf_pkg::BYTE_W-1:0]     ram_rdata;

    // decoded values of the held request
    logic [WIDE_W-1:0]               elen_wide;
    logic [vrrf_pkg::SUM_W-1:0]      need;
    logic                            too_wide;
    logic [vrrf_pkg::LEN_W-1:0]      rec_len;
    logic [vrrf_pkg::LEN_W-1:0]      read_len;
    logic [vrrf_pkg::SUM_W-1:0]      rec_span;
    logic [vrrf_pkg::IDX_W-1:0]      addr_inc;

    // result fields of the finishing cycle
    logic                            fin;
    logic [vrrf_pkg::STATUS_W-1:0]   fin_status;
    logic [vrrf_pkg::BYTE_W-1:0]     fin_data;
    logic [vrrf_pkg::LEN_W-1:0]      fin_len;

    vrrf_ram #(
        .WIDTH (vrrf_pkg::BYTE_W),
        .DEPTH (vrrf_pkg::RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // request decode
    assign elen_wide = WIDE_W'(req_reg.elem_len);
    assign need      = vrrf_pkg::SUM_W'(req_reg.elem_len)
                     + vrrf_pkg::SUM_W'(vrrf_pkg::HEADER_BYTES);
    assign too_wide  = ((WIDE_W + 1)'(req_reg.elem_len) >= HDR_LIMIT);
    assign rec_len   = vrrf_pkg::LEN_W'(hdr_reg);
    assign read_len  = (req_reg.max_len < rec_len) ? req_reg.max_len : rec_len;
    assign rec_span  = vrrf_pkg::SUM_W'(rec_len) + vrrf_pkg::SUM_W'(vrrf_pkg::HEADER_BYTES);
    assign addr_inc  = wrap_idx(vrrf_pkg::SUM_W'(addr_reg) + vrrf_pkg::SUM_W'(1), size_reg);

    // handshake outputs
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // sequencer: one request at a time, ram accesses ordered so no read meets a write
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        size_next  = size_reg;
        rear_next  = rear_reg;
        front_next = front_reg;
        count_next = count_reg;
        free_next  = free_reg;
        fill_next  = fill_reg;
        hidx_next  = hidx_reg;
        addr_next  = addr_reg;
        hdr_next   = hdr_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        ram_we     = 1'b0;
        ram_waddr  = rear_reg;
        ram_wdata  = req_reg.data_byte;
        ram_re     = 1'b0;
        ram_raddr  = addr_reg;
        fin        = 1'b0;
        fin_status = vrrf_pkg::ST_OK;
        fin_data   = '0;
        fin_len    = '0;

        case (state_reg)
            S_IDLE:
            begin
                // buffer size write empties the queue
                if (cfg_valid)
                begin
                    size_next  = clamp_size(cfg_data);
                    rear_next  = '0;
                    front_next = '0;
                    count_next = '0;
                    free_next  = clamp_size(cfg_data);
                    fill_next  = '0;
                end
                if (start)
                begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (req_reg.req_type)
                    vrrf_pkg::REQ_PUSH_START:
                    begin
                        if (fill_reg != '0)
                        begin
                            fin        = 1'b1;
                            fin_status = vrrf_pkg::ST_SEQ_ERR;
                        end
                        else if (req_reg.elem_len == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = vrrf_pkg::ST_ZERO_LEN;
                        end
                        else if (too_wide || (vrrf_pkg::SUM_W'(free_reg) < need))
                        begin
                            fin        = 1'b1;
                            fin_status = vrrf_pkg::ST_NO_SPACE;
                        end
                        else
                        begin
                            addr_next  = rear_reg;
                            hidx_next  = '0;
                            state_next = S_HWR;
                        end
                    end
                    vrrf_pkg::REQ_PUSH_DATA:
                    begin
                        fin = 1'b1;
                        if (fill_reg == '0)
                        begin
                            fin_status = vrrf_pkg::ST_SEQ_ERR;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            rear_next = wrap_idx(vrrf_pkg::SUM_W'(rear_reg)
                                                 + vrrf_pkg::SUM_W'(1), size_reg);
                            fill_next = fill_reg - vrrf_pkg::LEN_W'(1);
                            // record commits on its last byte
                            if (fill_reg == vrrf_pkg::LEN_W'(1))
                            begin
                                count_next = count_reg + vrrf_pkg::COUNT_W'(1);
                            end
                        end
                    end
                    vrrf_pkg::REQ_READ,
                    vrrf_pkg::REQ_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = vrrf_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            addr_next  = front_reg;
                            hidx_next  = '0;
                            hdr_next   = '0;
                            state_next = S_HRD;
                        end
                    end
                    vrrf_pkg::REQ_FLUSH:
                    begin
                        fin        = 1'b1;
                        rear_next  = '0;
                        front_next = '0;
                        count_next = '0;
                        free_next  = size_reg;
                        fill_next  = '0;
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        fin_status = vrrf_pkg::ST_SEQ_ERR;
                    end
                endcase
            end
            S_HWR:
            begin
                // write one little-endian header byte per cycle
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = elen_wide[8*hidx_reg +: 8];
                addr_next = addr_inc;
                if (hidx_reg == HIDX_LAST)
                begin
                    fin       = 1'b1;
                    rear_next = addr_inc;
                    free_next = vrrf_pkg::SIZE_W'(vrrf_pkg::SUM_W'(free_reg) - need);
                    fill_next = req_reg.elem_len;
                end
                else
                begin
                    hidx_next = hidx_reg + vrrf_pkg::HIDX_W'(1);
                end
            end
            S_HRD:
            begin
                // issue header byte read
                ram_re     = 1'b1;
                state_next = S_HCAP;
            end
            S_HCAP:
            begin
                // collect header byte
                hdr_next[8*hidx_reg +: 8] = ram_rdata;
                if (hidx_reg == HIDX_LAST)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    hidx_next  = hidx_reg + vrrf_pkg::HIDX_W'(1);
                    addr_next  = addr_inc;
                    state_next = S_HRD;
                end
            end
            S_ACT:
            begin
                if (req_reg.req_type == vrrf_pkg::REQ_READ)
                begin
                    if (req_reg.read_offset >= read_len)
                    begin
                        fin        = 1'b1;
                        fin_status = vrrf_pkg::ST_OFFSET;
                        fin_len    = read_len;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = wrap_idx(vrrf_pkg::SUM_W'(front_reg)
                                              + vrrf_pkg::SUM_W'(vrrf_pkg::HEADER_BYTES)
                                              + vrrf_pkg::SUM_W'(req_reg.read_offset),
                                              size_reg);
                        state_next = S_DRD;
                    end
                end
                else
                begin
                    // pop releases header plus data
                    fin        = 1'b1;
                    fin_len    = rec_len;
                    front_next = wrap_idx(vrrf_pkg::SUM_W'(front_reg) + rec_span, size_reg);
                    count_next = count_reg - vrrf_pkg::COUNT_W'(1);
                    free_next  = vrrf_pkg::SIZE_W'(vrrf_pkg::SUM_W'(free_reg) + rec_span);
                end
            end
            S_DRD:
            begin
                fin      = 1'b1;
                fin_data = ram_rdata;
                fin_len  = read_len;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result register load
        if (fin)
        begin
            state_next          = S_IDLE;
            done_next           = 1'b1;
            rsp_next.status     = fin_status;
            rsp_next.data_out   = fin_data;
            rsp_next.length_out = fin_len;
            rsp_next.count_out  = vrrf_pkg::CNT_OUT_W'(count_next);
            rsp_next.free_out   = vrrf_pkg::FREE_OUT_W'(free_next);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= vrrf_pkg::SIZE_W'(vrrf_pkg::RING_BYTES);
            rear_reg  <= '0;
            front_reg <= '0;
            count_reg <= '0;
            free_reg  <= vrrf_pkg::SIZE_W'(vrrf_pkg::RING_BYTES);
            fill_reg  <= '0;
            hidx_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            rear_reg  <= rear_next;
            front_reg <= front_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            fill_reg  <= fill_next;
            hidx_reg  <= hidx_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        addr_reg <= addr_next;
        hdr_reg  <= hdr_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

[rtl/core/vrrf_ram.sv]
// ---------------------------------------------------------------------------
// vrrf_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module vrrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/vrrf_checker.sv]
// ---------------------------------------------------------------------------
// vrrf_checker
// port-level checks of the record ring fifo, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "variable_record_ring_fifo_macros.svh"

module vrrf_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       done,
    input wire vrrf_pkg::vrrf_rsp_t        rsp
);

    // no result in the cycle right after a request transfer
    `VRRF_ASSERT_NEXT(a_no_early_result, clk, rst_n, start && !busy, !done)

    // a result marks the end of the request, the block is free again
    `VRRF_ASSERT_IMPLY(a_free_on_result, clk, rst_n, done, !busy)

    // status is one of the defined codes
    `VRRF_ASSERT_IMPLY(a_status_code, clk, rst_n, done, rsp.status == vrrf_pkg::ST_OK || rsp.status == vrrf_pkg::ST_ZERO_LEN || rsp.status == vrrf_pkg::ST_NO_SPACE || rsp.status == vrrf_pkg::ST_EMPTY || rsp.status == vrrf_pkg::ST_SEQ_ERR || rsp.status == vrrf_pkg::ST_OFFSET)

    // data byte is zero on any failed request
    `VRRF_ASSERT_IMPLY(a_data_zero, clk, rst_n, done && rsp.status != vrrf_pkg::ST_OK, rsp.data_out == '0)

    // free bytes never exceed the ring
    `VRRF_ASSERT_IMPLY(a_free_bound, clk, rst_n, done, 32'(rsp.free_out) <= 32'(vrrf_pkg::RING_BYTES))

endmodule

bind variable_record_ring_fifo vrrf_checker u_vrrf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
